[rtl/i2dec_pkg.sv]
// Shared constants and types for the signed integer to decimal text converter.
`default_nettype none

package i2dec_pkg;

  // Width of the signed input integer
  localparam int VALUE_WIDTH = 64;

  // Magnitude bits converted per pipeline stage
  localparam int STEP = 8;
  localparam int NUM_STAGES = (VALUE_WIDTH + STEP - 1) / STEP;
  localparam int MAG_W = NUM_STAGES * STEP;

  // Decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1)
  localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_W = 4 * NUM_DIGITS;
  localparam int IDX_W = $clog2(NUM_DIGITS);

  // Character codes
  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  // Item as it moves down the conversion pipeline
  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
    logic [MAG_W-1:0] bin;
  } dd_t;

endpackage

`default_nettype wire

[rtl/i2dec_mag.sv]
// Entry stage: split the signed input into sign and unsigned magnitude.
`default_nettype none

module i2dec_mag (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   valid_i,
  output logic                                        ready_o,
  input  wire logic signed [i2dec_pkg::VALUE_WIDTH-1:0] value_i,
  output logic                                        valid_o,
  input  wire logic                                   ready_i,
  output i2dec_pkg::dd_t                              data_o
);
  import i2dec_pkg::*;

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  dd_t                    data_d;
  dd_t                    data_q;
  logic                   valid_q;

  // Negate in unsigned arithmetic so the most negative value stays exact
  always_comb begin
    raw = $unsigned(value_i);
    mag = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
    data_d.neg = raw[VALUE_WIDTH-1];
    data_d.bcd = '0;
    data_d.bin = MAG_W'(mag);
  end

  assign ready_o = !valid_q || ready_i;

  // Hold valid across stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Capture payload when the stage advances
  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[rtl/i2dec_dabble.sv]
// One double-dabble stage: shift STEP magnitude bits into the BCD digits.
`default_nettype none

module i2dec_dabble (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire i2dec_pkg::dd_t data_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output i2dec_pkg::dd_t      data_o
);
  import i2dec_pkg::*;

  logic [BCD_W-1:0] bcd;
  logic [MAG_W-1:0] bin;
  dd_t              data_d;
  dd_t              data_q;
  logic             valid_q;

  // Add 3 to every digit of five or more, then shift in the next bit
  always_comb begin
    bcd = data_i.bcd;
    bin = data_i.bin;
    for (int s = 0; s < STEP; s++) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        if (bcd[4*k +: 4] >= 4'd5) begin
          bcd[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
        end
      end
      bcd = {bcd[BCD_W-2:0], bin[MAG_W-1]};
      bin = {bin[MAG_W-2:0], 1'b0};
    end
    data_d.neg = data_i.neg;
    data_d.bcd = bcd;
    data_d.bin = bin;
  end

  assign ready_o = !valid_q || ready_i;

  // Hold valid across stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Capture payload when the stage advances
  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[rtl/i2dec_ser.sv]
// Output serializer: sign and significant digits, one char per unstalled cycle.
`default_nettype none

module i2dec_ser (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  output logic                                 ready_o,
  input  wire i2dec_pkg::dd_t                  data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [i2dec_pkg::CHAR_W-1:0]         char_code_o,
  output logic                                 is_last_o
);
  import i2dec_pkg::*;

  // Index of the most significant nonzero digit, zero for a zero value
  function automatic logic [IDX_W-1:0] top_digit(input logic [BCD_W-1:0] bcd);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        r = IDX_W'(i);
      end
    end
    return r;
  endfunction

  logic              have_q, have_d;
  logic              neg_q, neg_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d;
  logic              oval_q, oval_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;
  logic              free;
  logic              take;
  logic              done;
  logic              load;
  logic [3:0]        digit;

  assign free  = !oval_q || !out_stall_i;
  assign take  = free && have_q;
  assign done  = take && !neg_q && (idx_q == '0);
  assign ready_o = !have_q || done;
  assign load  = valid_i && ready_o;
  assign digit = bcd_q[4*idx_q +: 4];

  // Pick the next character and advance through the held item
  always_comb begin
    have_d = have_q;
    neg_d  = neg_q;
    idx_d  = idx_q;
    bcd_d  = bcd_q;
    oval_d = oval_q;
    char_d = char_q;
    last_d = last_q;
    if (take) begin
      oval_d = 1'b1;
      if (neg_q) begin
        char_d = CHAR_MINUS;
        last_d = 1'b0;
        neg_d  = 1'b0;
      end else begin
        char_d = CHAR_ZERO + CHAR_W'(digit);
        last_d = (idx_q == '0);
        if (idx_q == '0) begin
          have_d = 1'b0;
        end else begin
          idx_d = idx_q - IDX_W'(1);
        end
      end
    end else if (!out_stall_i) begin
      oval_d = 1'b0;
    end
    if (load) begin
      have_d = 1'b1;
      neg_d  = data_i.neg;
      bcd_d  = data_i.bcd;
      idx_d  = top_digit(data_i.bcd);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      have_q <= have_d;
      oval_q <= oval_d;
    end
  end

  // Payload state
  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    idx_q  <= idx_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = oval_q;
  assign char_code_o = char_q;
  assign is_last_o   = last_q;

endmodule

`default_nettype wire

[rtl/signed_int_to_decimal_ascii.sv]
// Top level of the signed integer to decimal ASCII converter.
// Converts one signed VALUE_WIDTH-bit integer per item into its decimal text, most
// significant character first, with a leading '-' for negative values and is_last_o
// on the final character; zero gives a single '0'. The magnitude passes through a
// sign stage and NUM_STAGES double-dabble stages (eight bits each, nine stages in
// all at 64 bits), then the serializer's item register and its character register.
// The output serializer emits one character per cycle while out_stall_i is low;
// an item has 1 to 20 characters at 64 bits, and the next item is taken as the
// last character is emitted. Items queue in the pipeline behind a busy serializer;
// in_stall_o rises once every stage is full.
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [i2dec_pkg::VALUE_WIDTH-1:0] value_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic [i2dec_pkg::CHAR_W-1:0]                char_code_o,
  output logic                                        is_last_o
);
  import i2dec_pkg::*;

  dd_t  stg_data [NUM_STAGES+1];
  logic stg_vld  [NUM_STAGES+1];
  logic stg_rdy  [NUM_STAGES+1];
  logic in_rdy;

  assign in_stall_o = !in_rdy;

  // Sign and magnitude
  i2dec_mag u_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_rdy),
    .value_i (value_i),
    .valid_o (stg_vld[0]),
    .ready_i (stg_rdy[0]),
    .data_o  (stg_data[0])
  );

  // Binary to BCD, one group of bits per stage
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dabble
    i2dec_dabble u_dabble (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_vld[g]),
      .ready_o (stg_rdy[g]),
      .data_i  (stg_data[g]),
      .valid_o (stg_vld[g+1]),
      .ready_i (stg_rdy[g+1]),
      .data_o  (stg_data[g+1])
    );
  end

  // Character output
  i2dec_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stg_vld[NUM_STAGES]),
    .ready_o     (stg_rdy[NUM_STAGES]),
    .data_i      (stg_data[NUM_STAGES]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .is_last_o   (is_last_o)
  );

endmodule

`default_nettype wire

[rtl/i2dec_chk.sv]
// Port-level checks for the decimal text converter, bound to the top level.
`default_nettype none

module i2dec_chk (
  input wire logic                                   clk_i,
  input wire logic                                   rst_ni,
  input wire logic                                   in_valid_i,
  input wire logic                                   in_stall_o,
  input wire logic signed [i2dec_pkg::VALUE_WIDTH-1:0] value_i,
  input wire logic                                   out_valid_o,
  input wire logic                                   out_stall_i,
  input wire logic [i2dec_pkg::CHAR_W-1:0]           char_code_o,
  input wire logic                                   is_last_o
);
  import i2dec_pkg::*;

  // A stalled item stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // A stalled item keeps its payload
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(char_code_o) && $stable(is_last_o))
    else $error("output item changed while stalled");

  // Only a sign or a decimal digit comes out
  a_char_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o == CHAR_MINUS) ||
                    ((char_code_o >= CHAR_ZERO) && (char_code_o <= CHAR_ZERO + 6'd9)))
    else $error("output character out of range");

  // A sign never ends the text
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (char_code_o == CHAR_MINUS) |-> !is_last_o)
    else $error("minus sign flagged as last");

  // A sign is followed at once by a nonzero leading digit
  a_minus_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (char_code_o == CHAR_MINUS)
    |=> out_valid_o && (char_code_o != CHAR_ZERO) && (char_code_o != CHAR_MINUS))
    else $error("bad character after minus sign");

endmodule

bind signed_int_to_decimal_ascii i2dec_chk u_i2dec_chk (.*);

`default_nettype wire

[test/signed_int_to_decimal_ascii_tb.sv]
// Testbench for the signed integer to decimal ASCII converter.
module signed_int_to_decimal_ascii_tb;
  import i2dec_pkg::*;

  // One character of a number's decimal text
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [VALUE_WIDTH-1:0] value_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [CHAR_W-1:0]             char_code_o;
  logic                          is_last_o;

  text_char_t pending_chars[$];
  int         fail_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         hold_off = 1'b0;

  signed_int_to_decimal_ascii u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .is_last_o   (is_last_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Queue the decimal text of one accepted value
  function automatic void push_decimal_text(input logic [VALUE_WIDTH-1:0] val);
    logic [VALUE_WIDTH-1:0] mag;
    logic [3:0]             digits[$];
    logic                   neg;
    text_char_t             ch;
    neg = val[VALUE_WIDTH-1];
    mag = neg ? -val : val;
    do begin
      digits.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      ch.code = CHAR_MINUS;
      ch.last = 1'b0;
      pending_chars.push_back(ch);
    end
    foreach (digits[i]) begin
      ch.code = CHAR_ZERO + CHAR_W'(digits[i]);
      ch.last = (i == digits.size() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  // Offer one value, hold it until accepted; entered and left at a falling edge
  task automatic send_value(input logic signed [VALUE_WIDTH-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    push_decimal_text(val);
    @(negedge clk_i);
  endtask

  // Pick a value: full width, shortened, small, or next to a power of ten
  function automatic logic signed [VALUE_WIDTH-1:0] random_value();
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] pow;
    int                     sel;
    raw = {$urandom, $urandom};
    sel = $urandom_range(3);
    case (sel)
      0: ;
      1: raw = raw >> $urandom_range(VALUE_WIDTH - 1);
      2: raw = VALUE_WIDTH'($urandom_range(999));
      default: begin
        pow = 1;
        repeat ($urandom_range(18)) pow = pow * 10;
        raw = pow + VALUE_WIDTH'($urandom_range(2)) - 1;
      end
    endcase
    if (sel != 0 && $urandom_range(1) == 1) raw = -raw;
    return raw;
  endfunction

  task automatic run_random_items(input int count, input int sender_pct,
                                  input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    repeat (count) send_value(random_value());
  endtask

  // Extremes, every digit, the sign, zero and powers of ten
  task automatic test_directed_values();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_value(64'sd0);
    send_value(64'sd1);
    send_value(-64'sd1);
    send_value(64'sd9);
    send_value(64'sd10);
    send_value(-64'sd10);
    send_value(64'sd99);
    send_value(64'sd100);
    send_value(64'sd1234567890);
    send_value(-64'sd9876543210);
    send_value(64'sd999999999999999999);
    send_value(64'sd1000000000000000000);
    send_value(-64'sd1000000000000000000);
    send_value(64'sh7FFF_FFFF_FFFF_FFFF);
    send_value(64'sh7FFF_FFFF_FFFF_FFFE);
    send_value(64'sh8000_0000_0000_0000);
    send_value(64'sh8000_0000_0000_0001);
    send_value(64'sh5555_5555_5555_5555);
    send_value(64'shAAAA_AAAA_AAAA_AAAA);
    send_value(64'sd0);
  endtask

  task automatic test_random_slow_receiver();
    run_random_items(25, 7, 72);
  endtask

  task automatic test_random_slow_sender();
    run_random_items(25, 72, 7);
  endtask

  task automatic test_random_full_rate();
    run_random_items(25, 0, 0);
  endtask

  // Hold the receiver off long enough that the pipeline fills and stalls input
  task automatic test_input_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        @(posedge clk_i);
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (25) send_value(random_value());
    join
  endtask

  // Drive the receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // Check each accepted character against the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: char_code %0d is_last %0b", char_code_o, is_last_o);
        fail_count++;
      end else begin
        if (char_code_o !== pending_chars[0].code) begin
          $error("char_code mismatch: expected %0d actual %0d",
                 pending_chars[0].code, char_code_o);
          fail_count++;
        end
        if (is_last_o !== pending_chars[0].last) begin
          $error("is_last mismatch: expected %0b actual %0b",
                 pending_chars[0].last, is_last_o);
          fail_count++;
        end
        void'(pending_chars.pop_front());
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    out_stall_i = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_values();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_random_full_rate();
    test_input_backpressure();

    in_valid_i    <= 1'b0;
    recv_idle_pct = 0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0 && pending_chars.size() == 0) begin
      $display("PASS signed_int_to_decimal_ascii");
    end else begin
      $display("FAIL signed_int_to_decimal_ascii");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #400000;
    $display("FAIL signed_int_to_decimal_ascii");
    $finish;
  end

endmodule

[filelist.f]
rtl/i2dec_pkg.sv
rtl/i2dec_mag.sv
rtl/i2dec_dabble.sv
rtl/i2dec_ser.sv
rtl/signed_int_to_decimal_ascii.sv
rtl/i2dec_chk.sv
test/signed_int_to_decimal_ascii_tb.sv
